// ===== sv/pgtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Parity game text parser package
// Phase codes, character constants, record and error codes, and the record
// types shared by the parser and the output queue.
// ----------------------------------------------------------------------------
package pgtp_pkg;

    localparam int VALUE_BITS = 32;
    localparam int ACC_EXT_W  = VALUE_BITS + 4;
    localparam int KW_LEN     = 7;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_Y      = 8'h79;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    typedef enum logic [2:0] {
        REC_HEADER   = 3'd0,
        REC_NODE     = 3'd1,
        REC_SUCC     = 3'd2,
        REC_NAME     = 3'd3,
        REC_NODE_END = 3'd4,
        REC_DONE     = 3'd5,
        REC_ERROR    = 3'd6
    } rec_kind_t;

    typedef enum logic [2:0] {
        ERR_KEYWORD = 3'd0,
        ERR_DIGIT   = 3'd1,
        ERR_SPACE   = 3'd2,
        ERR_OWNER   = 3'd3,
        ERR_SEMI    = 3'd4,
        ERR_OVERFLOW = 3'd5,
        ERR_NAME    = 3'd6
    } err_code_t;

    typedef enum logic [4:0] {
        PH_START      = 5'd0,
        PH_KEYWORD    = 5'd1,
        PH_HDR_FIRST  = 5'd2,
        PH_HDR_NUM    = 5'd3,
        PH_SKIP_NODE  = 5'd4,
        PH_ID         = 5'd5,
        PH_SKIP_PRIO  = 5'd6,
        PH_PRIO       = 5'd7,
        PH_SKIP_OWNER = 5'd8,
        PH_OWNER      = 5'd9,
        PH_SKIP_SUCC  = 5'd10,
        PH_SUCC_FIRST = 5'd11,
        PH_SUCC       = 5'd12,
        PH_SKIP_TAIL  = 5'd13,
        PH_NAME       = 5'd14,
        PH_SEMI       = 5'd15,
        PH_HALT       = 5'd16
    } phase_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [31:0] value;
        logic [31:0] node_id;
        logic [31:0] priority_res;
        logic        owner;
        logic        last_successor;
        logic [2:0]  error_code;
    } rec_t;

    typedef struct packed {
        logic valid0;
        logic valid1;
        rec_t rec0;
        rec_t rec1;
    } push_t;

    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CH_P;
            3'd1:    c = CH_A;
            3'd2:    c = CH_R;
            3'd3:    c = CH_I;
            3'd4:    c = CH_T;
            3'd5:    c = CH_Y;
            3'd6:    c = CH_SPACE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic rec_t make_rec(input rec_kind_t kind, input logic [31:0] value,
                                      input logic node_info, input logic [31:0] id,
                                      input logic [31:0] prio, input logic own,
                                      input logic last, input err_code_t code);
        rec_t r;
        r.record_kind    = kind;
        r.value          = value;
        r.node_id        = node_info ? id : 32'd0;
        r.priority_res   = node_info ? prio : 32'd0;
        r.owner          = node_info ? own : 1'b0;
        r.last_successor = last;
        r.error_code     = code;
        return r;
    endfunction

endpackage

// ===== sv/pgtp_in_if.sv =====
// ----------------------------------------------------------------------------
// Text input channel
// Valid/ready channel carrying one command and one text byte per beat.
// ----------------------------------------------------------------------------
interface pgtp_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] text_byte;

    modport source (output valid, output command, output text_byte, input ready);
    modport sink   (input valid, input command, input text_byte, output ready);
endinterface

// ===== sv/pgtp_out_if.sv =====
// ----------------------------------------------------------------------------
// Record output channel
// Valid/ready channel carrying one parse record per beat.
// ----------------------------------------------------------------------------
interface pgtp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [31:0] value;
    logic [31:0] node_id;
    logic [31:0] priority_res;
    logic        owner;
    logic        last_successor;
    logic [2:0]  error_code;

    modport source (output valid, output record_kind, output value, output node_id,
                    output priority_res, output owner, output last_successor,
                    output error_code, input ready);
    modport sink   (input valid, input record_kind, input value, input node_id,
                    input priority_res, input owner, input last_successor,
                    input error_code, output ready);
endinterface

// ===== sv/pgtp_parse.sv =====
// ----------------------------------------------------------------------------
// Parser core
// Input beat register followed by the byte-level parse step. Each beat
// updates the parse state and pushes zero, one or two records.
// ----------------------------------------------------------------------------
module pgtp_parse (
    input  logic                clk,
    input  logic                rst_n,
    pgtp_in_if.sink             text_in,
    input  logic                space_ok,
    output pgtp_pkg::push_t     push
);

    logic                              stage_valid_reg;
    logic                              stage_cmd_reg;
    logic [7:0]                        stage_byte_reg;
    logic                              advance;

    pgtp_pkg::phase_t                  phase_reg, phase_next;
    logic [pgtp_pkg::VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [pgtp_pkg::VALUE_BITS-1:0]   id_reg, id_next;
    logic [pgtp_pkg::VALUE_BITS-1:0]   prio_reg, prio_next;
    logic                              own_reg, own_next;
    logic [31:0]                       pos_reg, pos_next;
    logic [2:0]                        kw_reg, kw_next;
    logic                              cmt_reg, cmt_next;

    logic                              eof;
    logic [7:0]                        b;
    logic                              is_dig, is_gap, is_blank, skip;
    logic [pgtp_pkg::ACC_EXT_W-1:0]    acc_wide;
    logic                              ovf;
    logic [pgtp_pkg::VALUE_BITS-1:0]   dig_val;
    logic [31:0]                       id32, prio32, acc32;
    logic                              fail0, fail1;
    pgtp_pkg::err_code_t               code0, code1;
    pgtp_pkg::push_t                   push_c;

    assign advance       = stage_valid_reg && space_ok;
    assign text_in.ready = !stage_valid_reg || space_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            stage_valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.ready && text_in.valid)
        begin
            stage_cmd_reg  <= text_in.command;
            stage_byte_reg <= text_in.text_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pgtp_pkg::PH_START;
            acc_reg   <= '0;
            id_reg    <= '0;
            prio_reg  <= '0;
            own_reg   <= 1'b0;
            pos_reg   <= '0;
            kw_reg    <= '0;
            cmt_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            id_reg    <= id_next;
            prio_reg  <= prio_next;
            own_reg   <= own_next;
            pos_reg   <= pos_next;
            kw_reg    <= kw_next;
            cmt_reg   <= cmt_next;
        end
    end

    assign eof      = (stage_cmd_reg == pgtp_pkg::CMD_EOF);
    assign b        = stage_byte_reg;
    assign is_dig   = !eof && (b >= pgtp_pkg::CH_ZERO) && (b <= pgtp_pkg::CH_NINE);
    assign is_gap   = !eof && ((b == pgtp_pkg::CH_SPACE) || (b == pgtp_pkg::CH_TAB));
    assign is_blank = is_gap || (!eof && ((b == pgtp_pkg::CH_LF) || (b == pgtp_pkg::CH_CR)));
    assign dig_val  = pgtp_pkg::VALUE_BITS'(b[3:0]);
    assign acc_wide = (pgtp_pkg::ACC_EXT_W'(acc_reg) << 3)
                    + (pgtp_pkg::ACC_EXT_W'(acc_reg) << 1)
                    + pgtp_pkg::ACC_EXT_W'(b[3:0]);
    assign ovf      = |acc_wide[pgtp_pkg::ACC_EXT_W-1:pgtp_pkg::VALUE_BITS];
    assign id32     = 32'(id_reg);
    assign prio32   = 32'(prio_reg);
    assign acc32    = 32'(acc_reg);
    assign skip     = !eof && ((phase_reg == pgtp_pkg::PH_START)
                    || (phase_reg == pgtp_pkg::PH_SKIP_NODE)
                    || (phase_reg == pgtp_pkg::PH_SKIP_PRIO)
                    || (phase_reg == pgtp_pkg::PH_SKIP_OWNER)
                    || (phase_reg == pgtp_pkg::PH_SKIP_SUCC)
                    || (phase_reg == pgtp_pkg::PH_SKIP_TAIL));

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        own_next   = own_reg;
        pos_next   = pos_reg;
        kw_next    = kw_reg;
        cmt_next   = cmt_reg;
        fail0      = 1'b0;
        fail1      = 1'b0;
        code0      = pgtp_pkg::ERR_KEYWORD;
        code1      = pgtp_pkg::ERR_KEYWORD;
        push_c     = '0;

        if (skip && cmt_reg)
        begin
            if (b == pgtp_pkg::CH_LF)
            begin
                cmt_next = 1'b0;
            end
        end
        else if (skip && (b == pgtp_pkg::CH_PCT))
        begin
            cmt_next = 1'b1;
        end
        else if (skip && is_blank)
        begin
            cmt_next = cmt_reg;
        end
        else
        begin
            unique case (phase_reg)
                pgtp_pkg::PH_START,
                pgtp_pkg::PH_SKIP_NODE:
                begin
                    if ((phase_reg == pgtp_pkg::PH_START) && !eof && (b == pgtp_pkg::CH_P))
                    begin
                        phase_next = pgtp_pkg::PH_KEYWORD;
                        kw_next    = 3'd1;
                    end
                    else if (eof)
                    begin
                        push_c.valid0 = 1'b1;
                        push_c.rec0   = pgtp_pkg::make_rec(pgtp_pkg::REC_DONE, 32'd0, 1'b0,
                            id32, prio32, own_reg, 1'b0, pgtp_pkg::ERR_KEYWORD);
                    end
                    else if (is_dig)
                    begin
                        acc_next   = dig_val;
                        phase_next = pgtp_pkg::PH_ID;
                    end
                    else
                    begin
                        fail0 = 1'b1;
                        code0 = pgtp_pkg::ERR_DIGIT;
                    end
                end
                pgtp_pkg::PH_KEYWORD:
                begin
                    if ((kw_reg < 3'(pgtp_pkg::KW_LEN)) && !eof
                        && (b == pgtp_pkg::keyword_char(kw_reg)))
                    begin
                        kw_next = kw_reg + 3'd1;
                        if (kw_reg + 3'd1 == 3'(pgtp_pkg::KW_LEN))
                        begin
                            phase_next = pgtp_pkg::PH_HDR_FIRST;
                        end
                    end
                    else
                    begin
                        fail0 = 1'b1;
                        code0 = pgtp_pkg::ERR_KEYWORD;
                    end
                end
                pgtp_pkg::PH_HDR_FIRST,
                pgtp_pkg::PH_SKIP_PRIO,
                pgtp_pkg::PH_SKIP_OWNER,
                pgtp_pkg::PH_SKIP_SUCC,
                pgtp_pkg::PH_SUCC_FIRST:
                begin
                    if (!is_dig)
                    begin
                        fail0 = 1'b1;
                        code0 = pgtp_pkg::ERR_DIGIT;
                    end
                    else
                    begin
                        acc_next = dig_val;
                        case (phase_reg)
                            pgtp_pkg::PH_HDR_FIRST:  phase_next = pgtp_pkg::PH_HDR_NUM;
                            pgtp_pkg::PH_SKIP_PRIO:  phase_next = pgtp_pkg::PH_PRIO;
                            pgtp_pkg::PH_SKIP_OWNER: phase_next = pgtp_pkg::PH_OWNER;
                            default:                 phase_next = pgtp_pkg::PH_SUCC;
                        endcase
                    end
                end
                pgtp_pkg::PH_HDR_NUM,
                pgtp_pkg::PH_ID,
                pgtp_pkg::PH_PRIO,
                pgtp_pkg::PH_OWNER,
                pgtp_pkg::PH_SUCC:
                begin
                    if (is_dig)
                    begin
                        if (ovf)
                        begin
                            fail0 = 1'b1;
                            code0 = pgtp_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            acc_next = acc_wide[pgtp_pkg::VALUE_BITS-1:0];
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            pgtp_pkg::PH_HDR_NUM:
                            begin
                                if (!eof && (b == pgtp_pkg::CH_SEMI))
                                begin
                                    phase_next    = pgtp_pkg::PH_SKIP_NODE;
                                    push_c.valid0 = 1'b1;
                                    push_c.rec0   = pgtp_pkg::make_rec(pgtp_pkg::REC_HEADER,
                                        acc32, 1'b0, id32, prio32, own_reg, 1'b0,
                                        pgtp_pkg::ERR_KEYWORD);
                                end
                                else
                                begin
                                    fail0 = 1'b1;
                                    code0 = pgtp_pkg::ERR_SEMI;
                                end
                            end
                            pgtp_pkg::PH_ID,
                            pgtp_pkg::PH_PRIO:
                            begin
                                if (!is_gap)
                                begin
                                    fail0 = 1'b1;
                                    code0 = pgtp_pkg::ERR_SPACE;
                                end
                                else if (phase_reg == pgtp_pkg::PH_ID)
                                begin
                                    id_next    = acc_reg;
                                    phase_next = pgtp_pkg::PH_SKIP_PRIO;
                                end
                                else
                                begin
                                    prio_next  = acc_reg;
                                    phase_next = pgtp_pkg::PH_SKIP_OWNER;
                                end
                            end
                            pgtp_pkg::PH_OWNER:
                            begin
                                if (acc_reg > pgtp_pkg::VALUE_BITS'(1))
                                begin
                                    fail0 = 1'b1;
                                    code0 = pgtp_pkg::ERR_OWNER;
                                end
                                else if (!is_gap)
                                begin
                                    fail0 = 1'b1;
                                    code0 = pgtp_pkg::ERR_SPACE;
                                end
                                else
                                begin
                                    own_next      = acc_reg[0];
                                    phase_next    = pgtp_pkg::PH_SKIP_SUCC;
                                    push_c.valid0 = 1'b1;
                                    push_c.rec0   = pgtp_pkg::make_rec(pgtp_pkg::REC_NODE,
                                        32'd0, 1'b1, id32, prio32, acc_reg[0], 1'b0,
                                        pgtp_pkg::ERR_KEYWORD);
                                end
                            end
                            default:
                            begin
                                push_c.valid0 = 1'b1;
                                if (!eof && (b == pgtp_pkg::CH_COMMA))
                                begin
                                    phase_next  = pgtp_pkg::PH_SUCC_FIRST;
                                    push_c.rec0 = pgtp_pkg::make_rec(pgtp_pkg::REC_SUCC,
                                        acc32, 1'b1, id32, prio32, own_reg, 1'b0,
                                        pgtp_pkg::ERR_KEYWORD);
                                end
                                else
                                begin
                                    phase_next  = pgtp_pkg::PH_SKIP_TAIL;
                                    push_c.rec0 = pgtp_pkg::make_rec(pgtp_pkg::REC_SUCC,
                                        acc32, 1'b1, id32, prio32, own_reg, 1'b1,
                                        pgtp_pkg::ERR_KEYWORD);
                                    if (!eof && (b == pgtp_pkg::CH_PCT))
                                    begin
                                        cmt_next = 1'b1;
                                    end
                                    else if (is_blank)
                                    begin
                                        cmt_next = cmt_reg;
                                    end
                                    else if (!eof && (b == pgtp_pkg::CH_QUOTE))
                                    begin
                                        phase_next = pgtp_pkg::PH_NAME;
                                    end
                                    else if (!eof && (b == pgtp_pkg::CH_SEMI))
                                    begin
                                        phase_next    = pgtp_pkg::PH_SKIP_NODE;
                                        push_c.valid1 = 1'b1;
                                        push_c.rec1   = pgtp_pkg::make_rec(
                                            pgtp_pkg::REC_NODE_END, 32'd0, 1'b1, id32,
                                            prio32, own_reg, 1'b0, pgtp_pkg::ERR_KEYWORD);
                                    end
                                    else
                                    begin
                                        fail1 = 1'b1;
                                        code1 = pgtp_pkg::ERR_SEMI;
                                    end
                                end
                            end
                        endcase
                    end
                end
                pgtp_pkg::PH_SKIP_TAIL,
                pgtp_pkg::PH_SEMI:
                begin
                    if ((phase_reg == pgtp_pkg::PH_SKIP_TAIL) && !eof
                        && (b == pgtp_pkg::CH_QUOTE))
                    begin
                        phase_next = pgtp_pkg::PH_NAME;
                    end
                    else if (!eof && (b == pgtp_pkg::CH_SEMI))
                    begin
                        phase_next    = pgtp_pkg::PH_SKIP_NODE;
                        push_c.valid0 = 1'b1;
                        push_c.rec0   = pgtp_pkg::make_rec(pgtp_pkg::REC_NODE_END, 32'd0,
                            1'b1, id32, prio32, own_reg, 1'b0, pgtp_pkg::ERR_KEYWORD);
                    end
                    else
                    begin
                        fail0 = 1'b1;
                        code0 = pgtp_pkg::ERR_SEMI;
                    end
                end
                pgtp_pkg::PH_NAME:
                begin
                    if (eof)
                    begin
                        fail0 = 1'b1;
                        code0 = pgtp_pkg::ERR_NAME;
                    end
                    else if (b == pgtp_pkg::CH_QUOTE)
                    begin
                        phase_next = pgtp_pkg::PH_SEMI;
                    end
                    else
                    begin
                        push_c.valid0 = 1'b1;
                        push_c.rec0   = pgtp_pkg::make_rec(pgtp_pkg::REC_NAME, 32'(b), 1'b1,
                            id32, prio32, own_reg, 1'b0, pgtp_pkg::ERR_KEYWORD);
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (fail0)
        begin
            phase_next    = pgtp_pkg::PH_HALT;
            cmt_next      = 1'b0;
            push_c.valid0 = 1'b1;
            push_c.rec0   = pgtp_pkg::make_rec(pgtp_pkg::REC_ERROR, pos_reg, 1'b0,
                id32, prio32, own_reg, 1'b0, code0);
        end
        if (fail1)
        begin
            phase_next    = pgtp_pkg::PH_HALT;
            cmt_next      = 1'b0;
            push_c.valid1 = 1'b1;
            push_c.rec1   = pgtp_pkg::make_rec(pgtp_pkg::REC_ERROR, pos_reg, 1'b0,
                id32, prio32, own_reg, 1'b0, code1);
        end

        pos_next = pos_reg + 32'd1;

        // rearm for a new text
        if (eof)
        begin
            phase_next = pgtp_pkg::PH_START;
            acc_next   = '0;
            id_next    = '0;
            prio_next  = '0;
            own_next   = 1'b0;
            pos_next   = '0;
            kw_next    = '0;
            cmt_next   = 1'b0;
        end

        // hold everything when no beat advances
        if (!advance)
        begin
            phase_next = phase_reg;
            acc_next   = acc_reg;
            id_next    = id_reg;
            prio_next  = prio_reg;
            own_next   = own_reg;
            pos_next   = pos_reg;
            kw_next    = kw_reg;
            cmt_next   = cmt_reg;
            push_c     = '0;
        end
    end

    assign push = push_c;

endmodule

// ===== sv/pgtp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Record output queue
// Small queue that takes up to two records per cycle and delivers one record
// per beat; reports room for a full two-record push.
// ----------------------------------------------------------------------------
module pgtp_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  pgtp_pkg::push_t   push,
    output logic              space_ok,
    pgtp_out_if.source        rec_out
);

    pgtp_pkg::rec_t                    mem_reg [pgtp_pkg::OUT_DEPTH];
    logic [pgtp_pkg::OUT_PTR_W-1:0]    wp_reg, wp_next;
    logic [pgtp_pkg::OUT_PTR_W-1:0]    rp_reg, rp_next;
    logic [pgtp_pkg::OUT_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [pgtp_pkg::OUT_CNT_W-1:0]    n_wr;
    logic                              rd;
    pgtp_pkg::rec_t                    first_rec;
    pgtp_pkg::rec_t                    head;

    assign first_rec = push.valid0 ? push.rec0 : push.rec1;
    assign n_wr      = pgtp_pkg::OUT_CNT_W'(push.valid0) + pgtp_pkg::OUT_CNT_W'(push.valid1);
    assign rd        = rec_out.valid && rec_out.ready;
    assign space_ok  = (cnt_reg <= pgtp_pkg::OUT_CNT_W'(pgtp_pkg::OUT_DEPTH - 2));

    assign wp_next  = wp_reg + pgtp_pkg::OUT_PTR_W'(n_wr);
    assign rp_next  = rp_reg + pgtp_pkg::OUT_PTR_W'(rd);
    assign cnt_next = cnt_reg + n_wr - pgtp_pkg::OUT_CNT_W'(rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid0 || push.valid1)
        begin
            mem_reg[wp_reg] <= first_rec;
        end
        if (push.valid0 && push.valid1)
        begin
            mem_reg[wp_reg + pgtp_pkg::OUT_PTR_W'(1)] <= push.rec1;
        end
    end

    assign head                   = mem_reg[rp_reg];
    assign rec_out.valid          = (cnt_reg != '0);
    assign rec_out.record_kind    = head.record_kind;
    assign rec_out.value          = head.value;
    assign rec_out.node_id        = head.node_id;
    assign rec_out.priority_res   = head.priority_res;
    assign rec_out.owner          = head.owner;
    assign rec_out.last_successor = head.last_successor;
    assign rec_out.error_code     = head.error_code;

endmodule

// ===== sv/parity_game_text_parser.sv =====
// ----------------------------------------------------------------------------
// Parity game text parser
// Streams parity-game text one byte per beat and emits parse records.
//
// text_in carries a command (byte or end of input) and a text byte per beat.
// rec_out carries one record per beat: header, node, successor, name byte,
// node end, done or error with code and byte position.
// A beat enters an input register, is parsed once the queue has room for two
// records, and its records land in a four-entry output queue, from which the
// first record is offered; the input register and the queue lie between the
// input and the output handshake.
// Throughput is one input beat per cycle while the queue keeps room for two
// records; a beat that ends a successor list may yield two records, which
// the single-record output port drains one after the other.
// When the receiver stalls, the queue fills and text_in.ready drops once it
// holds more than two records; nothing is lost.
// Reset clears the parse state to the start of a text and empties the queue.
// End of input rearms the parser; unless halted, it gives done or an error.
// ----------------------------------------------------------------------------
module parity_game_text_parser (
    input  logic          clk,
    input  logic          rst_n,
    pgtp_in_if.sink       text_in,
    pgtp_out_if.source    rec_out
);

    pgtp_pkg::push_t push;
    logic            space_ok;

    pgtp_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .space_ok (space_ok),
        .push     (push)
    );

    pgtp_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .rec_out  (rec_out)
    );

endmodule

// ===== dv/parity_game_text_parser_test.sv =====
// ----------------------------------------------------------------------------
// Parity game text parser testbench
// Sends short parity-game texts byte by byte, each closed by an end of input,
// into the parser and checks every record that comes out. A few directed
// texts come first: an empty text, a broken header, a number one past the
// 32-bit limit, an owner above one and an unterminated name. Random texts
// follow: mostly well-formed headers and node lines with random numbers,
// blanks, comments and names, some of them corrupted or cut short, and some
// pure noise. Expected records come from a parser model kept in the bench;
// the directed error and done records are typed in by hand. Both channels
// idle at random, the record side holds off once for a long stretch, and the
// text side waits once for the record side to drain.
// ----------------------------------------------------------------------------
module parity_game_text_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pgtp_pkg::*;

    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;
    localparam int unsigned END_MARK = 256;
    // error_code reads zero outside error records
    localparam err_code_t NO_ERROR = ERR_KEYWORD;

    localparam int RANDOM_BEATS = 1850;
    localparam int STALL_AT     = 400;
    localparam int STALL_CYCLES = 150;
    localparam int STEADY_FROM  = 900;
    localparam int STEADY_TO    = 1200;
    localparam int PAUSE_AT     = 1500;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic       command;
        logic [7:0] text_byte;
        bit         pinned;
        rec_t       want;
    } beat_t;

    logic clk;
    logic rst_n;

    pgtp_in_if  text_if();
    pgtp_out_if rec_if();

    parity_game_text_parser DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_if),
        .rec_out (rec_if)
    );

    beat_t      plan[$];
    logic [7:0] draft[$];
    rec_t       beat_recs[$];
    rec_t       awaited_recs[$];

    int mismatches  = 0;
    int beats_taken = 0;
    int stall_left  = 0;
    bit stall_done  = 1'b0;

    // parser model state
    phase_t          parse_phase;
    longint unsigned acc;
    logic [31:0]     cur_id;
    logic [31:0]     cur_prio;
    logic            cur_owner;
    logic [31:0]     byte_pos;
    int unsigned     word_pos;
    bit              skipping_comment;

    logic [7:0] header_word [KW_LEN] = '{CH_P, CH_A, CH_R, CH_I, CH_T, CH_Y, CH_SPACE};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_parser();
        parse_phase      = PH_START;
        acc              = 0;
        cur_id           = '0;
        cur_prio         = '0;
        cur_owner        = 1'b0;
        byte_pos         = '0;
        word_pos         = 0;
        skipping_comment = 1'b0;
    endfunction

    function automatic void add_record(rec_kind_t kind, logic [31:0] val, bit node_info,
                                       bit last, err_code_t code);
        rec_t r;
        r.record_kind    = kind;
        r.value          = val;
        r.node_id        = node_info ? cur_id : '0;
        r.priority_res   = node_info ? cur_prio : '0;
        r.owner          = node_info ? cur_owner : 1'b0;
        r.last_successor = last;
        r.error_code     = code;
        beat_recs.insert(beat_recs.size(), r);
    endfunction

    function automatic void reject(err_code_t code);
        parse_phase      = PH_HALT;
        skipping_comment = 1'b0;
        add_record(REC_ERROR, byte_pos, 1'b0, 1'b0, code);
    endfunction

    // returns 1 when the same symbol must be handled again
    function automatic bit take_symbol(int unsigned sym, bit eof);
        phase_t          ph;
        bit              digit;
        bit              gap;
        longint unsigned d;
        ph    = parse_phase;
        digit = sym >= CH_ZERO && sym <= CH_NINE;
        gap   = sym == CH_SPACE || sym == CH_TAB;
        d     = digit ? sym - CH_ZERO : 0;
        if (!eof && (ph == PH_START || ph == PH_SKIP_NODE || ph == PH_SKIP_PRIO ||
                     ph == PH_SKIP_OWNER || ph == PH_SKIP_SUCC || ph == PH_SKIP_TAIL))
        begin
            if (skipping_comment)
            begin
                if (sym == CH_LF)
                    skipping_comment = 1'b0;
                return 1'b0;
            end
            if (sym == CH_PCT)
            begin
                skipping_comment = 1'b1;
                return 1'b0;
            end
            if (gap || sym == CH_LF || sym == CH_CR)
                return 1'b0;
        end
        case (ph)
            PH_START, PH_SKIP_NODE:
            begin
                if (ph == PH_START && sym == CH_P)
                begin
                    parse_phase = PH_KEYWORD;
                    word_pos    = 1;
                end
                else if (eof)
                    add_record(REC_DONE, '0, 1'b0, 1'b0, NO_ERROR);
                else if (digit)
                begin
                    acc         = d;
                    parse_phase = PH_ID;
                end
                else
                    reject(ERR_DIGIT);
            end
            PH_KEYWORD:
            begin
                if (word_pos < KW_LEN && sym == header_word[word_pos])
                begin
                    word_pos++;
                    if (word_pos == KW_LEN)
                        parse_phase = PH_HDR_FIRST;
                end
                else
                    reject(ERR_KEYWORD);
            end
            PH_HDR_FIRST, PH_SKIP_PRIO, PH_SKIP_OWNER, PH_SKIP_SUCC, PH_SUCC_FIRST:
            begin
                if (!digit)
                    reject(ERR_DIGIT);
                else
                begin
                    acc         = d;
                    parse_phase = (ph == PH_HDR_FIRST)  ? PH_HDR_NUM :
                                  (ph == PH_SKIP_PRIO)  ? PH_PRIO :
                                  (ph == PH_SKIP_OWNER) ? PH_OWNER : PH_SUCC;
                end
            end
            PH_HDR_NUM, PH_ID, PH_PRIO, PH_OWNER, PH_SUCC:
            begin
                if (digit)
                begin
                    if (acc > (VALUE_MAX - d) / 10)
                        reject(ERR_OVERFLOW);
                    else
                        acc = acc * 10 + d;
                end
                else
                begin
                    case (ph)
                        PH_HDR_NUM:
                        begin
                            if (sym != CH_SEMI)
                                reject(ERR_SEMI);
                            else
                            begin
                                parse_phase = PH_SKIP_NODE;
                                add_record(REC_HEADER, acc[31:0], 1'b0, 1'b0, NO_ERROR);
                            end
                        end
                        PH_ID:
                        begin
                            if (!gap)
                                reject(ERR_SPACE);
                            else
                            begin
                                cur_id      = acc[31:0];
                                parse_phase = PH_SKIP_PRIO;
                            end
                        end
                        PH_PRIO:
                        begin
                            if (!gap)
                                reject(ERR_SPACE);
                            else
                            begin
                                cur_prio    = acc[31:0];
                                parse_phase = PH_SKIP_OWNER;
                            end
                        end
                        PH_OWNER:
                        begin
                            if (acc > 1)
                                reject(ERR_OWNER);
                            else if (!gap)
                                reject(ERR_SPACE);
                            else
                            begin
                                cur_owner   = acc[0];
                                parse_phase = PH_SKIP_SUCC;
                                add_record(REC_NODE, '0, 1'b1, 1'b0, NO_ERROR);
                            end
                        end
                        default:
                        begin
                            if (sym == CH_COMMA)
                            begin
                                parse_phase = PH_SUCC_FIRST;
                                add_record(REC_SUCC, acc[31:0], 1'b1, 1'b0, NO_ERROR);
                            end
                            else
                            begin
                                add_record(REC_SUCC, acc[31:0], 1'b1, 1'b1, NO_ERROR);
                                parse_phase = PH_SKIP_TAIL;
                                return 1'b1;
                            end
                        end
                    endcase
                end
            end
            PH_SKIP_TAIL:
            begin
                if (sym == CH_QUOTE)
                    parse_phase = PH_NAME;
                else if (sym == CH_SEMI)
                begin
                    parse_phase = PH_SKIP_NODE;
                    add_record(REC_NODE_END, '0, 1'b1, 1'b0, NO_ERROR);
                end
                else
                    reject(ERR_SEMI);
            end
            PH_NAME:
            begin
                if (eof)
                    reject(ERR_NAME);
                else if (sym == CH_QUOTE)
                    parse_phase = PH_SEMI;
                else
                    add_record(REC_NAME, sym, 1'b1, 1'b0, NO_ERROR);
            end
            PH_SEMI:
            begin
                if (sym == CH_SEMI)
                begin
                    parse_phase = PH_SKIP_NODE;
                    add_record(REC_NODE_END, '0, 1'b1, 1'b0, NO_ERROR);
                end
                else
                    reject(ERR_SEMI);
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void parse_beat(logic command, logic [7:0] ch);
        bit again;
        if (command == CMD_EOF)
        begin
            do
                again = take_symbol(END_MARK, 1'b1);
            while (again);
            clear_parser();
        end
        else
        begin
            do
                again = take_symbol(ch, 1'b0);
            while (again);
            byte_pos = byte_pos + 1;
        end
    endfunction

    function automatic void add_byte(logic command, logic [7:0] ch);
        beat_t b;
        b.command   = command;
        b.text_byte = ch;
        b.pinned    = 1'b0;
        b.want      = '0;
        plan.insert(plan.size(), b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(CMD_BYTE, s[i]);
    endfunction

    function automatic void add_pinned(logic command, logic [7:0] ch, rec_kind_t kind,
                                       logic [31:0] val, err_code_t code);
        beat_t b;
        b.command          = command;
        b.text_byte        = ch;
        b.pinned           = 1'b1;
        b.want             = '0;
        b.want.record_kind = kind;
        b.want.value       = val;
        b.want.error_code  = code;
        plan.insert(plan.size(), b);
    endfunction

    function automatic bit chance(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void put_char(logic [7:0] c);
        draft.insert(draft.size(), c);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    function automatic void put_gap();
        put_char(chance(50) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void rand_blanks();
        logic [7:0] c;
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0: put_char(CH_SPACE);
                1: put_char(CH_TAB);
                2: put_char(CH_LF);
                default: put_char(CH_CR);
            endcase
        end
        if (chance(10))
        begin
            put_char(CH_PCT);
            repeat ($urandom_range(0, 4))
            begin
                c = 8'($urandom_range(0, 255));
                put_char(c == CH_LF ? CH_SPACE : c);
            end
            put_char(CH_LF);
        end
    endfunction

    function automatic string rand_number();
        longint unsigned v;
        int unsigned     pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            v = $urandom_range(0, 9);
        else if (pick < 82)
            v = $urandom_range(10, 999);
        else if (pick < 95)
            v = $urandom;
        else if (pick < 99)
            v = VALUE_MAX;
        else
            v = VALUE_MAX + 1 + $urandom_range(0, 99999);
        return chance(5) ? {"0", $sformatf("%0d", v)} : $sformatf("%0d", v);
    endfunction

    function automatic void rand_node();
        logic [7:0] c;
        put_str(rand_number());
        put_gap();
        rand_blanks();
        put_str(rand_number());
        put_gap();
        rand_blanks();
        if (chance(92))
            put_char(chance(50) ? CH_ZERO : CH_ZERO + 8'd1);
        else
            put_str(rand_number());
        put_gap();
        rand_blanks();
        for (int i = $urandom_range(1, 3); i > 0; i--)
        begin
            put_str(rand_number());
            if (i > 1)
                put_char(CH_COMMA);
        end
        rand_blanks();
        if (chance(40))
        begin
            put_char(CH_QUOTE);
            repeat ($urandom_range(0, 5))
            begin
                c = 8'($urandom_range(0, 255));
                put_char(c == CH_QUOTE ? CH_CR : c);
            end
            put_char(CH_QUOTE);
        end
        put_char(CH_SEMI);
        rand_blanks();
    endfunction

    function automatic void rand_text();
        int unsigned keep;
        draft.delete();
        if (chance(5))
        begin
            repeat ($urandom_range(1, 12))
                put_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            rand_blanks();
            if (chance(30))
            begin
                put_str("parity ");
                put_str(rand_number());
                put_char(CH_SEMI);
                rand_blanks();
            end
            repeat ($urandom_range(0, 4))
                rand_node();
            if (draft.size() > 0 && chance(15))
                draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
            if (draft.size() > 0 && chance(10))
            begin
                keep = $urandom_range(0, draft.size() - 1);
                while (draft.size() > keep)
                    void'(draft.pop_back());
            end
        end
        foreach (draft[i])
            add_byte(CMD_BYTE, draft[i]);
        add_byte(CMD_EOF, 8'h00);
    endfunction

    function automatic bit steady();
        return beats_taken >= STEADY_FROM && beats_taken < STEADY_TO;
    endfunction

    function automatic bit sender_rests();
        return !steady() && stall_left == 0 && chance(38);
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0h got %0h", $time, field, want, got);
        end
    endfunction

    // text side
    initial
    begin
        int directed_beats;
        text_if.valid     <= 1'b0;
        text_if.command   <= CMD_BYTE;
        text_if.text_byte <= 8'h00;
        rst_n             <= 1'b0;
        clear_parser();

        add_pinned(CMD_EOF, 8'h00, REC_DONE, 0, NO_ERROR);
        add_byte(CMD_BYTE, CH_P);
        add_pinned(CMD_BYTE, 8'hFF, REC_ERROR, 1, ERR_KEYWORD);
        add_byte(CMD_EOF, 8'h00);
        add_text("429496729");
        add_pinned(CMD_BYTE, "6", REC_ERROR, 9, ERR_OVERFLOW);
        add_byte(CMD_EOF, 8'h00);
        add_text("0 0 2");
        add_pinned(CMD_BYTE, CH_SPACE, REC_ERROR, 5, ERR_OWNER);
        add_byte(CMD_EOF, 8'h00);
        add_text("0\t7 1 5\"");
        add_byte(CMD_BYTE, 8'h00);
        add_pinned(CMD_EOF, 8'h00, REC_ERROR, 9, ERR_NAME);
        directed_beats = plan.size();
        while (plan.size() < directed_beats + RANDOM_BEATS)
            rand_text();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < plan.size(); i++)
        begin
            if (i == PAUSE_AT)
            begin
                text_if.valid <= 1'b0;
                do
                    @(posedge clk);
                while (awaited_recs.size() != 0);
            end
            while (sender_rests())
            begin
                text_if.valid <= 1'b0;
                @(posedge clk);
            end
            text_if.valid     <= 1'b1;
            text_if.command   <= plan[i].command;
            text_if.text_byte <= plan[i].text_byte;
            do
                @(posedge clk);
            while (!text_if.ready);
            beats_taken++;
            beat_recs.delete();
            parse_beat(plan[i].command, plan[i].text_byte);
            if (plan[i].pinned)
                awaited_recs.insert(awaited_recs.size(), plan[i].want);
            else
                foreach (beat_recs[k])
                    awaited_recs.insert(awaited_recs.size(), beat_recs[k]);
        end
        text_if.valid <= 1'b0;

        while (awaited_recs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_recs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // record side
    initial
    begin
        rec_t want;
        rec_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rec_if.valid === 1'b1 && rec_if.ready === 1'b1)
            begin
                if (awaited_recs.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: record kind %0d value %0h arrived with none expected",
                             $time, rec_if.record_kind, rec_if.value);
                end
                else
                begin
                    want = awaited_recs.pop_front();
                    check_field("record_kind", want.record_kind, rec_if.record_kind);
                    check_field("value", want.value, rec_if.value);
                    check_field("node_id", want.node_id, rec_if.node_id);
                    check_field("priority_res", want.priority_res, rec_if.priority_res);
                    check_field("owner", want.owner, rec_if.owner);
                    check_field("last_successor", want.last_successor, rec_if.last_successor);
                    check_field("error_code", want.error_code, rec_if.error_code);
                end
            end
            if (!stall_done && beats_taken >= STALL_AT)
            begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rec_if.ready <= 1'b0;
            end
            else
                rec_if.ready <= steady() || !chance(38);
        end
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
